// ----- rtl/core/bac_pkg.sv -----
// ----------------------------------------------------------------------------
// bac_pkg
// Shared constants, request and status codes, and an order helper for the buddy
// allocator with garbage collection.
// ----------------------------------------------------------------------------
package bac_pkg;

  // Default sizing
  localparam int MAX_ORDER_DEF  = 10;
  localparam int OWNER_BITS_DEF = 8;
  localparam int MAX_BLOCKS_DEF = 512;

  // Pool order after reset (clamped to the maximum order)
  localparam int POOL_ORDER_RST = 10;

  // Fixed field widths
  localparam int ACTION_W = 2;
  localparam int SIZE_W   = 11;
  localparam int STATUS_W = 2;
  localparam int OFFSET_W = 10;
  localparam int ORDER_W  = 4;
  localparam int CFG_W    = 4;

  // Request actions
  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_COLLECT = 2'd2;

  // Result status
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OK_GC    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd3;

  // Smallest order n >= 1 with 2^n >= size, capped at 12
  function automatic logic [ORDER_W-1:0] need_order(input logic [SIZE_W-1:0] size);
    logic [ORDER_W-1:0] n;
    n = 4'd1;
    for (int i = 1; i < 12; i++) begin
      if ((12'd1 << i) < {1'b0, size}) begin
        n = ORDER_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

// ----- rtl/core/buddy_allocator_with_collect_unit.sv -----
// ----------------------------------------------------------------------------
// buddy_allocator_with_collect_unit
// Buddy allocator over a 2^pool_order byte pool with owner-based garbage
// marking, collection and buddy merging. Block list kept in address order
// in one synchronous memory.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------
//  cfg     | in        | cfg_wr_en          | cfg_wr_data (pool order)
//  in      | in        | in_valid/in_stall  | in_action, in_owner_id,
//          |           |                    | in_request_size
//  out     | out       | out_valid/out_stall| out_status, out_block_offset,
//          |           |                    | out_block_order
//
// One request at a time. A zero-size or unused-code request goes straight to
// the result register; a release makes one mark sweep over the table. An
// allocate, after its sweep, shifts the list up when the block must be split,
// then writes the granted block and one split-off half per split level. A
// collection reads every entry once and merges buddies on a stack; a failed
// first try adds a collection and a second sweep. Every pass goes through the
// single table read port. Reset and pool-order writes leave one free block; no
// clearing pass. A stalled result register holds the block in its final state.
// ----------------------------------------------------------------------------
module buddy_allocator_with_collect_unit
  import bac_pkg::*;
#(
  parameter int MAX_ORDER  = MAX_ORDER_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [OWNER_BITS-1:0] in_owner_id,
  input  logic [SIZE_W-1:0]     in_request_size,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [OFFSET_W-1:0]   out_block_offset,
  output logic [ORDER_W-1:0]    out_block_order
);

  localparam int OFF_W = MAX_ORDER;
  localparam int ORD_W = ($clog2(MAX_ORDER + 1) > ORDER_W) ? $clog2(MAX_ORDER + 1) : ORDER_W;
  localparam int OWN_W = OWNER_BITS;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W = $clog2(MAX_BLOCKS);

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [ORD_W-1:0] ord;
    logic [OWN_W-1:0] own;
    logic             used;
    logic             garb;
  } blk_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_SHIFT = 8'b0000_0100,
    S_FILL  = 8'b0000_1000,
    S_CISS  = 8'b0001_0000,
    S_CDAT  = 8'b0010_0000,
    S_CPOP  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // Left block a and right neighbor b are free buddies of equal order
  function automatic logic can_merge(input blk_t a, input blk_t b);
    logic [OFF_W:0]   msk;
    logic [OFF_W-1:0] step;
    msk  = ({{OFF_W{1'b0}}, 1'b1} << (a.ord + 1'b1)) - 1'b1;
    step = OFF_W'(1) << a.ord;
    return !a.used && !b.used && (a.ord == b.ord) &&
           ((a.off & msk[OFF_W-1:0]) == '0) && (b.off == a.off + step);
  endfunction

  // Garbage block becomes free
  function automatic blk_t free_garb(input blk_t e);
    blk_t r;
    r = e;
    if (e.used && e.garb) begin
      r.used = 1'b0;
      r.garb = 1'b0;
      r.own  = '0;
    end
    return r;
  endfunction

  // Block table memory
  blk_t             mem [MAX_BLOCKS];
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  blk_t             mem_wdata;
  blk_t             rd_q_r;
  logic             rd_fresh_r;
  blk_t             rd_ent;
  blk_t             rst_ent;

  // Control and datapath registers
  state_t                state_r, state_nxt;
  logic [ACTION_W-1:0]   act_r, act_nxt;
  logic [OWN_W-1:0]      id_r, id_nxt;
  logic [ORD_W-1:0]      need_r, need_nxt;
  logic                  retry_r, retry_nxt;
  logic                  mark_r, mark_nxt;
  logic [CNT_W-1:0]      si_r, si_nxt;
  logic                  dv_r, dv_nxt;
  logic [IDX_W-1:0]      di_r, di_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      best_r, best_nxt;
  logic [ORD_W-1:0]      bord_r, bord_nxt;
  logic [OFF_W-1:0]      boff_r, boff_nxt;
  logic [CNT_W-1:0]      sh_r, sh_nxt;
  logic [ORD_W-1:0]      m_r, m_nxt;
  logic [CNT_W-1:0]      ci_r, ci_nxt;
  logic [CNT_W-1:0]      w_r, w_nxt;
  blk_t                  top_r, top_nxt;
  logic                  topv_r, topv_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [ORD_W-1:0]      pool_r, pool_nxt;
  logic                  fresh_r, fresh_nxt;
  logic [STATUS_W-1:0]   rs_st_r, rs_st_nxt;
  logic [OFFSET_W-1:0]   rs_off_r, rs_off_nxt;
  logic [ORDER_W-1:0]    rs_ord_r, rs_ord_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_st_r, out_st_nxt;
  logic [OFFSET_W-1:0]   out_off_r, out_off_nxt;
  logic [ORDER_W-1:0]    out_ord_r, out_ord_nxt;

  // Memory ports: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q_r <= mem[mem_raddr];
    end
  end

  // Entry 0 reads as the single full-pool block until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_fresh_r <= 1'b0;
    end else if (mem_re) begin
      rd_fresh_r <= fresh_r && (mem_raddr == '0);
    end
  end

  always_comb begin
    rst_ent      = '0;
    rst_ent.ord  = pool_r;
    rd_ent       = rd_fresh_r ? rst_ent : rd_q_r;
  end

  // Next-state logic
  always_comb begin
    logic [ORD_W-1:0]   d;
    logic [CNT_W-1:0]   wm1;
    logic [CNT_W-1:0]   wm2;
    logic [CNT_W-1:0]   tmp;
    logic [CNT_W:0]     grow;
    logic [ORD_W-1:0]   sh_amt;
    logic [CFG_W-1:0]   cv;
    blk_t               e;
    blk_t               b;

    state_nxt     = state_r;
    act_nxt       = act_r;
    id_nxt        = id_r;
    need_nxt      = need_r;
    retry_nxt     = retry_r;
    mark_nxt      = mark_r;
    si_nxt        = si_r;
    dv_nxt        = dv_r;
    di_nxt        = di_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    bord_nxt      = bord_r;
    boff_nxt      = boff_r;
    sh_nxt        = sh_r;
    m_nxt         = m_r;
    ci_nxt        = ci_r;
    w_nxt         = w_r;
    top_nxt       = top_r;
    topv_nxt      = topv_r;
    cnt_nxt       = cnt_r;
    pool_nxt      = pool_r;
    fresh_nxt     = fresh_r;
    rs_st_nxt     = rs_st_r;
    rs_off_nxt    = rs_off_r;
    rs_ord_nxt    = rs_ord_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_off_nxt   = out_off_r;
    out_ord_nxt   = out_ord_r;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    d      = bord_r - need_r;
    wm1    = w_r - 1'b1;
    wm2    = w_r - 2'd2;
    tmp    = '0;
    grow   = {1'b0, cnt_r} + (CNT_W + 1)'(d);
    sh_amt = need_r + m_r - 1'b1;
    cv     = cfg_wr_data;
    e      = free_garb(rd_ent);
    b      = rd_ent;

    // Result register drains
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // Take a request
      S_IDLE: begin
        if (in_valid) begin
          act_nxt    = in_action;
          id_nxt     = in_owner_id;
          need_nxt   = ORD_W'(need_order(in_request_size));
          retry_nxt  = 1'b0;
          mark_nxt   = 1'b1;
          si_nxt     = '0;
          dv_nxt     = 1'b0;
          found_nxt  = 1'b0;
          ci_nxt     = '0;
          w_nxt      = '0;
          topv_nxt   = 1'b0;
          rs_st_nxt  = ST_OK;
          rs_off_nxt = '0;
          rs_ord_nxt = '0;
          case (in_action)
            ACT_ALLOC: begin
              if (in_request_size == '0) begin
                rs_st_nxt = ST_ZERO;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            ACT_RELEASE: state_nxt = S_SCAN;
            ACT_COLLECT: state_nxt = S_CISS;
            default:     state_nxt = S_DONE;
          endcase
        end
      end

      // Sweep: mark owner's blocks as garbage (first pass) and, for an allocate, search for a free block
      S_SCAN: begin
        if (dv_r) begin
          if (mark_r) begin
            mem_we    = 1'b1;
            mem_waddr = di_r;
            mem_wdata = rd_ent;
            if (rd_ent.used && (rd_ent.own == id_r)) begin
              mem_wdata.garb = 1'b1;
            end
          end
          if ((act_r == ACT_ALLOC) && !rd_ent.used) begin
            if (rd_ent.ord == need_r) begin
              found_nxt = 1'b1;
              best_nxt  = di_r;
              bord_nxt  = rd_ent.ord;
              boff_nxt  = rd_ent.off;
            end else if ((rd_ent.ord > need_r) && (!found_r || (rd_ent.ord < bord_r))) begin
              found_nxt = 1'b1;
              best_nxt  = di_r;
              bord_nxt  = rd_ent.ord;
              boff_nxt  = rd_ent.off;
            end
          end
        end
        if (si_r < cnt_r) begin
          mem_re    = 1'b1;
          mem_raddr = si_r[IDX_W-1:0];
          di_nxt    = si_r[IDX_W-1:0];
          si_nxt    = si_r + 1'b1;
          dv_nxt    = 1'b1;
        end else begin
          dv_nxt = 1'b0;
          if (!dv_r) begin
            if (act_r != ACT_ALLOC) begin
              state_nxt = S_DONE;
            end else if (found_r && (grow <= (CNT_W + 1)'(MAX_BLOCKS))) begin
              m_nxt  = '0;
              sh_nxt = cnt_r;
              state_nxt = (d == '0) ? S_FILL : S_SHIFT;
            end else if (!retry_r) begin
              retry_nxt = 1'b1;
              ci_nxt    = '0;
              w_nxt     = '0;
              topv_nxt  = 1'b0;
              state_nxt = S_CISS;
            end else begin
              rs_st_nxt = ST_NO_SPACE;
              state_nxt = S_DONE;
            end
          end
        end
      end

      // Open a gap of d entries after the chosen block, top entry first
      S_SHIFT: begin
        if (dv_r) begin
          tmp       = CNT_W'(di_r) + CNT_W'(d);
          mem_we    = 1'b1;
          mem_waddr = tmp[IDX_W-1:0];
          mem_wdata = rd_ent;
        end
        if (sh_r > (CNT_W'(best_r) + 1'b1)) begin
          tmp       = sh_r - 1'b1;
          mem_re    = 1'b1;
          mem_raddr = tmp[IDX_W-1:0];
          di_nxt    = tmp[IDX_W-1:0];
          sh_nxt    = tmp;
          dv_nxt    = 1'b1;
        end else begin
          dv_nxt = 1'b0;
          if (!dv_r) begin
            state_nxt = S_FILL;
          end
        end
      end

      // Write the granted block and its split-off right halves
      S_FILL: begin
        tmp       = CNT_W'(best_r) + CNT_W'(m_r);
        mem_we    = 1'b1;
        mem_waddr = tmp[IDX_W-1:0];
        if (m_r == '0) begin
          mem_wdata.off  = boff_r;
          mem_wdata.ord  = need_r;
          mem_wdata.own  = id_r;
          mem_wdata.used = 1'b1;
          mem_wdata.garb = 1'b0;
        end else begin
          mem_wdata.off  = boff_r + (OFF_W'(1) << sh_amt);
          mem_wdata.ord  = sh_amt;
        end
        if (m_r == d) begin
          cnt_nxt    = grow[CNT_W-1:0];
          rs_st_nxt  = retry_r ? ST_OK_GC : ST_OK;
          rs_off_nxt = OFFSET_W'(boff_r);
          rs_ord_nxt = ORDER_W'(need_r);
          state_nxt  = S_DONE;
        end else begin
          m_nxt = m_r + 1'b1;
        end
      end

      // Collect: fetch next entry or close the compacted list
      S_CISS: begin
        if (ci_r < cnt_r) begin
          mem_re    = 1'b1;
          mem_raddr = ci_r[IDX_W-1:0];
          ci_nxt    = ci_r + 1'b1;
          state_nxt = S_CDAT;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = w_r[IDX_W-1:0];
          mem_wdata = top_r;
          cnt_nxt   = w_r + 1'b1;
          if (act_r == ACT_ALLOC) begin
            mark_nxt  = 1'b0;
            si_nxt    = '0;
            dv_nxt    = 1'b0;
            found_nxt = 1'b0;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      // Collect: merge new entry into the stack top, or push the top
      S_CDAT: begin
        if (topv_r && can_merge(top_r, e)) begin
          top_nxt.ord = top_r.ord + 1'b1;
          if (w_r != '0) begin
            mem_re    = 1'b1;
            mem_raddr = wm1[IDX_W-1:0];
            state_nxt = S_CPOP;
          end else begin
            state_nxt = S_CISS;
          end
        end else begin
          if (topv_r) begin
            mem_we    = 1'b1;
            mem_waddr = w_r[IDX_W-1:0];
            mem_wdata = top_r;
            w_nxt     = w_r + 1'b1;
          end
          top_nxt   = e;
          topv_nxt  = 1'b1;
          state_nxt = S_CISS;
        end
      end

      // Collect: merge the stack top with the entry below it
      S_CPOP: begin
        if (can_merge(b, top_r)) begin
          top_nxt     = b;
          top_nxt.ord = b.ord + 1'b1;
          w_nxt       = wm1;
          if (w_r > 1) begin
            mem_re    = 1'b1;
            mem_raddr = wm2[IDX_W-1:0];
            state_nxt = S_CPOP;
          end else begin
            state_nxt = S_CISS;
          end
        end else begin
          state_nxt = S_CISS;
        end
      end

      // Hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = rs_st_r;
          out_off_nxt   = rs_off_r;
          out_ord_nxt   = rs_ord_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Entry 0 leaves its reset value once written
    if (mem_we && (mem_waddr == '0)) begin
      fresh_nxt = 1'b0;
    end

    // Pool order write: clamp and empty the table
    if (cfg_wr_en) begin
      if (cv == '0) begin
        pool_nxt = ORD_W'(1);
      end else if (int'(cv) > MAX_ORDER) begin
        pool_nxt = ORD_W'(MAX_ORDER);
      end else begin
        pool_nxt = ORD_W'(cv);
      end
      cnt_nxt   = CNT_W'(1);
      fresh_nxt = 1'b1;
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CNT_W'(1);
      pool_r      <= ORD_W'((POOL_ORDER_RST > MAX_ORDER) ? MAX_ORDER : POOL_ORDER_RST);
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
      dv_r        <= 1'b0;
      topv_r      <= 1'b0;
      retry_r     <= 1'b0;
      mark_r      <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pool_r      <= pool_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
      dv_r        <= dv_nxt;
      topv_r      <= topv_nxt;
      retry_r     <= retry_nxt;
      mark_r      <= mark_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    id_r      <= id_nxt;
    need_r    <= need_nxt;
    si_r      <= si_nxt;
    di_r      <= di_nxt;
    best_r    <= best_nxt;
    bord_r    <= bord_nxt;
    boff_r    <= boff_nxt;
    sh_r      <= sh_nxt;
    m_r       <= m_nxt;
    ci_r      <= ci_nxt;
    w_r       <= w_nxt;
    top_r     <= top_nxt;
    rs_st_r   <= rs_st_nxt;
    rs_off_r  <= rs_off_nxt;
    rs_ord_r  <= rs_ord_nxt;
    out_st_r  <= out_st_nxt;
    out_off_r <= out_off_nxt;
    out_ord_r <= out_ord_nxt;
  end

  // Ports
  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_st_r;
  assign out_block_offset = out_off_r;
  assign out_block_order  = out_ord_r;

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= CNT_W'(MAX_BLOCKS)))
    else $error("block count out of range");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  a_fail_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_st_r == ST_NO_SPACE) || (out_st_r == ST_ZERO))) |->
      ((out_off_r == '0) && (out_ord_r == '0)))
    else $error("failed request carries a block");

  a_compact_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CDAT) |-> (w_r < ci_r))
    else $error("compaction pointer overran read pointer");

endmodule
